FILE: rtl/emnm_pkg.sv
`default_nettype none

package emnm_pkg;

    localparam int DIV_BITS = 25;
    localparam int CW = 34;

    localparam logic FUNC_MODEL = 1'b0;
    localparam logic FUNC_NORMAL = 1'b1;

    localparam logic [1:0] COL_FIRST = 2'd0;
    localparam logic [1:0] COL_LAST_NORMAL = 2'd2;
    localparam logic [1:0] COL_TRANS = 2'd3;

    localparam logic signed [CW-1:0] GAIN30 = 34'sd652032874;
    localparam logic signed [CW-1:0] PI30 = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI30 = 34'sd1686629713;
    localparam logic signed [31:0] RECIP_MAX = 32'sh7FFFFFFF;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
        logic [15:0]          rem;
        logic [DIV_BITS-1:0]  q;
        logic [15:0]          mag;
    } lane_t;

    typedef struct packed {
        logic              func;
        logic [2:0][15:0]  sc;
        logic [2:0][31:0]  tr;
    } carry_t;

    function automatic logic signed [CW-1:0] atan30(input int i);
        logic signed [CW-1:0] a;
        case (i)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043837;
            3:       a = 34'sd133525159;
            4:       a = 34'sd67021687;
            5:       a = 34'sd33543516;
            6:       a = 34'sd16775851;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194283;
            9:       a = 34'sd2097149;
            10:      a = 34'sd1048576;
            11:      a = 34'sd524288;
            12:      a = 34'sd262144;
            13:      a = 34'sd131072;
            14:      a = 34'sd65536;
            15:      a = 34'sd32768;
            16:      a = 34'sd16384;
            17:      a = 34'sd8192;
            18:      a = 34'sd4096;
            19:      a = 34'sd2048;
            20:      a = 34'sd1024;
            21:      a = 34'sd512;
            22:      a = 34'sd256;
            23:      a = 34'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/euler_model_normal_matrix.sv
// Output: one column per cycle while m_axis_tready is high; an object is 4 columns (model)
// or 3 columns (normal), and a new request is taken only when the single result channel is
// empty or its last column is taken. Sine, cosine and reciprocal run in one pipeline,
// at most one CORDIC step and one quotient bit per stage; the whole pipeline stalls together.
// Reset clears the valid bits and the column counter; data registers are not reset.
`default_nettype none

module euler_model_normal_matrix
    import emnm_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // rotation_x, rotation_y, rotation_z, scale_x, scale_y, scale_z,
    // translation_x, translation_y, translation_z
    input  wire logic [191:0] s_axis_tdata,
    // func
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // row0_value, row1_value, row2_value, saturated, zero padding
    output logic [103:0]      m_axis_tdata,
    // which_matrix, column_index
    output logic [2:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int PIPE = (CORDIC_ITERATIONS > DIV_BITS) ? CORDIC_ITERATIONS : DIV_BITS;

    logic adv;
    logic take;
    logic last_col;

    lane_t  ln_reg [0:PIPE][0:2];
    carry_t cr_reg [0:PIPE];
    logic   v_reg  [0:PIPE];

    lane_t  in_next [0:2];
    carry_t in_cr;

    always_comb
    begin
        logic signed [15:0] ang;
        logic signed [15:0] sc;
        logic signed [CW-1:0] z0;
        in_cr.func = s_axis_tuser[0];
        for (int k = 0; k < 3; k++)
        begin
            in_cr.sc[k] = s_axis_tdata[48 + 16*k +: 16];
            in_cr.tr[k] = s_axis_tdata[96 + 32*k +: 32];
        end
        for (int l = 0; l < 3; l++)
        begin
            case (l)
                0:       ang = s_axis_tdata[31:16];
                1:       ang = s_axis_tdata[15:0];
                default: ang = s_axis_tdata[47:32];
            endcase
            z0 = {ang[15], ang, 17'b0};
            in_next[l].neg = 1'b0;
            in_next[l].z = z0;
            if (z0 > HALF_PI30)
            begin
                in_next[l].z = z0 - PI30;
                in_next[l].neg = 1'b1;
            end
            else if (z0 < -HALF_PI30)
            begin
                in_next[l].z = z0 + PI30;
                in_next[l].neg = 1'b1;
            end
            in_next[l].x = GAIN30;
            in_next[l].y = '0;
            in_next[l].rem = '0;
            in_next[l].q = '0;
            sc = s_axis_tdata[48 + 16*l +: 16];
            in_next[l].mag = sc[15] ? 16'(-sc) : 16'(sc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_reg[0] <= in_cr;
            for (int l = 0; l < 3; l++)
            begin
                ln_reg[0][l] <= in_next[l];
            end
        end
    end

    for (genvar i = 0; i < PIPE; i++)
    begin : g_it
        for (genvar l = 0; l < 3; l++)
        begin : g_ln
            lane_t cur;
            lane_t nx_cordic;
            lane_t nx;

            assign cur = ln_reg[i][l];

            if (i < CORDIC_ITERATIONS)
            begin : g_cordic
                always_comb
                begin
                    nx_cordic = cur;
                    if (!cur.z[CW-1])
                    begin
                        nx_cordic.x = cur.x - (cur.y >>> i);
                        nx_cordic.y = cur.y + (cur.x >>> i);
                        nx_cordic.z = cur.z - atan30(i);
                    end
                    else
                    begin
                        nx_cordic.x = cur.x + (cur.y >>> i);
                        nx_cordic.y = cur.y - (cur.x >>> i);
                        nx_cordic.z = cur.z + atan30(i);
                    end
                end
            end
            else
            begin : g_hold
                assign nx_cordic = cur;
            end

            if (i < DIV_BITS)
            begin : g_div
                always_comb
                begin
                    logic [DIV_BITS-1:0] num;
                    logic [16:0] t;
                    num = (DIV_BITS'(1) << (DIV_BITS - 1)) + DIV_BITS'(cur.mag >> 1);
                    t = {cur.rem, num[DIV_BITS-1-i]};
                    nx = nx_cordic;
                    if (t >= {1'b0, cur.mag})
                    begin
                        nx.rem = 16'(t - {1'b0, cur.mag});
                        nx.q[DIV_BITS-1-i] = 1'b1;
                    end
                    else
                    begin
                        nx.rem = t[15:0];
                    end
                end
            end
            else
            begin : g_nodiv
                assign nx = nx_cordic;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ln_reg[i+1][l] <= nx;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cr_reg[i+1] <= cr_reg[i];
            end
        end
    end

    logic signed [31:0] s_f_reg [0:2];
    logic signed [31:0] c_f_reg [0:2];
    logic signed [31:0] rc_f_reg [0:2];
    logic [2:0]         zf_f_reg;
    carry_t             cr_f_reg;

    logic signed [31:0] c1c3_reg, s1s2_reg, c2s3_reg, c1s2_reg, c3s1_reg;
    logic signed [31:0] c1s3_reg, c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg;
    logic signed [31:0] s2_m1_reg, s3_m1_reg;
    logic signed [31:0] rc_m1_reg [0:2];
    logic [2:0]         zf_m1_reg;
    carry_t             cr_m1_reg;

    logic signed [31:0] ta_reg, tb_reg, tc_reg, td_reg;
    logic signed [31:0] c1c3_m2_reg, c2s3_m2_reg, c3s1_m2_reg, c1s3_m2_reg;
    logic signed [31:0] c2c3_m2_reg, s1s3_m2_reg, c2s1_m2_reg, c1c2_m2_reg, s2_m2_reg;
    logic signed [31:0] rc_m2_reg [0:2];
    logic [2:0]         zf_m2_reg;
    carry_t             cr_m2_reg;

    logic signed [32:0] rot_reg [0:2][0:2];
    logic signed [31:0] rc_s_reg [0:2];
    logic [2:0]         zf_s_reg;
    carry_t             cr_s_reg;

    logic signed [64:0] pr_reg [0:2][0:2];
    logic [2:0]         zf_p_reg;
    carry_t             cr_p_reg;

    logic signed [31:0] val_reg [0:2][0:2];
    logic signed [31:0] val_next [0:2][0:2];
    logic [2:0]         sat_reg;
    logic [2:0]         sat_next;
    logic [2:0][31:0]   tr_reg;
    logic               func_reg;
    logic [1:0]         col_reg;
    logic [1:0]         col_next;

    logic v_f_reg, v_m1_reg, v_m2_reg, v_s_reg, v_p_reg, v_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f_reg  <= 1'b0;
            v_m1_reg <= 1'b0;
            v_m2_reg <= 1'b0;
            v_s_reg  <= 1'b0;
            v_p_reg  <= 1'b0;
            v_o_reg  <= 1'b0;
        end
        else if (adv)
        begin
            v_f_reg  <= v_reg[PIPE];
            v_m1_reg <= v_f_reg;
            v_m2_reg <= v_m1_reg;
            v_s_reg  <= v_m2_reg;
            v_p_reg  <= v_s_reg;
            v_o_reg  <= v_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] cx;
        logic signed [31:0] f;
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                sy = ln_reg[PIPE][l].neg ? -ln_reg[PIPE][l].y : ln_reg[PIPE][l].y;
                cx = ln_reg[PIPE][l].neg ? -ln_reg[PIPE][l].x : ln_reg[PIPE][l].x;
                s_f_reg[l] <= sy[31:0];
                c_f_reg[l] <= cx[31:0];
                zf_f_reg[l] <= (ln_reg[PIPE][l].mag == '0);
                if (ln_reg[PIPE][l].mag == '0)
                begin
                    rc_f_reg[l] <= RECIP_MAX;
                end
                else if (cr_reg[PIPE].sc[l][15])
                begin
                    rc_f_reg[l] <= -$signed({7'b0, ln_reg[PIPE][l].q});
                end
                else
                begin
                    rc_f_reg[l] <= $signed({7'b0, ln_reg[PIPE][l].q});
                end
            end
            cr_f_reg <= cr_reg[PIPE];

            c1c3_reg <= mul30(c_f_reg[0], c_f_reg[2]);
            s1s2_reg <= mul30(s_f_reg[0], s_f_reg[1]);
            c2s3_reg <= mul30(c_f_reg[1], s_f_reg[2]);
            c1s2_reg <= mul30(c_f_reg[0], s_f_reg[1]);
            c3s1_reg <= mul30(c_f_reg[2], s_f_reg[0]);
            c1s3_reg <= mul30(c_f_reg[0], s_f_reg[2]);
            c2c3_reg <= mul30(c_f_reg[1], c_f_reg[2]);
            s1s3_reg <= mul30(s_f_reg[0], s_f_reg[2]);
            c2s1_reg <= mul30(c_f_reg[1], s_f_reg[0]);
            c1c2_reg <= mul30(c_f_reg[0], c_f_reg[1]);
            s2_m1_reg <= s_f_reg[1];
            s3_m1_reg <= s_f_reg[2];
            rc_m1_reg <= rc_f_reg;
            zf_m1_reg <= zf_f_reg;
            cr_m1_reg <= cr_f_reg;

            ta_reg <= mul30(s1s2_reg, s3_m1_reg);
            tb_reg <= mul30(c1s2_reg, s3_m1_reg);
            tc_reg <= mul30(c3s1_reg, s2_m1_reg);
            td_reg <= mul30(c1c3_reg, s2_m1_reg);
            c1c3_m2_reg <= c1c3_reg;
            c2s3_m2_reg <= c2s3_reg;
            c3s1_m2_reg <= c3s1_reg;
            c1s3_m2_reg <= c1s3_reg;
            c2c3_m2_reg <= c2c3_reg;
            s1s3_m2_reg <= s1s3_reg;
            c2s1_m2_reg <= c2s1_reg;
            c1c2_m2_reg <= c1c2_reg;
            s2_m2_reg <= s2_m1_reg;
            rc_m2_reg <= rc_m1_reg;
            zf_m2_reg <= zf_m1_reg;
            cr_m2_reg <= cr_m1_reg;

            rot_reg[0][0] <= 33'(c1c3_m2_reg) + 33'(ta_reg);
            rot_reg[0][1] <= 33'(c2s3_m2_reg);
            rot_reg[0][2] <= 33'(tb_reg) - 33'(c3s1_m2_reg);
            rot_reg[1][0] <= 33'(tc_reg) - 33'(c1s3_m2_reg);
            rot_reg[1][1] <= 33'(c2c3_m2_reg);
            rot_reg[1][2] <= 33'(td_reg) + 33'(s1s3_m2_reg);
            rot_reg[2][0] <= 33'(c2s1_m2_reg);
            rot_reg[2][1] <= -33'(s2_m2_reg);
            rot_reg[2][2] <= 33'(c1c2_m2_reg);
            rc_s_reg <= rc_m2_reg;
            zf_s_reg <= zf_m2_reg;
            cr_s_reg <= cr_m2_reg;

            for (int k = 0; k < 3; k++)
            begin
                f = (cr_s_reg.func == FUNC_NORMAL) ? rc_s_reg[k]
                    : {{16{cr_s_reg.sc[k][15]}}, cr_s_reg.sc[k]};
                for (int r = 0; r < 3; r++)
                begin
                    pr_reg[k][r] <= 65'(f) * 65'(rot_reg[k][r]);
                end
            end
            zf_p_reg <= zf_s_reg;
            cr_p_reg <= cr_s_reg;

            val_reg <= val_next;
            sat_reg <= sat_next;
            tr_reg <= cr_p_reg.tr;
            func_reg <= cr_p_reg.func;
        end
    end

    always_comb
    begin
        logic signed [65:0] sum;
        logic signed [65:0] sh;
        for (int k = 0; k < 3; k++)
        begin
            sat_next[k] = (cr_p_reg.func == FUNC_NORMAL) && zf_p_reg[k];
            for (int r = 0; r < 3; r++)
            begin
                if (cr_p_reg.func == FUNC_NORMAL)
                begin
                    sum = 66'(pr_reg[k][r]) + 66'sd536870912;
                    sh = sum >>> 30;
                end
                else
                begin
                    sum = 66'(pr_reg[k][r]) + 66'sd2097152;
                    sh = sum >>> 22;
                end
                if (sh > 66'sd2147483647)
                begin
                    val_next[k][r] = 32'sh7FFFFFFF;
                    sat_next[k] = 1'b1;
                end
                else if (sh < -66'sd2147483648)
                begin
                    val_next[k][r] = 32'sh80000000;
                    sat_next[k] = 1'b1;
                end
                else
                begin
                    val_next[k][r] = sh[31:0];
                end
            end
        end
    end

    assign last_col = (func_reg == FUNC_NORMAL) ? (col_reg == COL_LAST_NORMAL)
                                                : (col_reg == COL_TRANS);
    assign take = !v_o_reg || (m_axis_tready && last_col);
    assign adv = take;
    assign s_axis_tready = adv;

    always_comb
    begin
        col_next = col_reg;
        if (v_o_reg && m_axis_tready)
        begin
            col_next = last_col ? COL_FIRST : col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= COL_FIRST;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    always_comb
    begin
        m_axis_tdata = '0;
        case (col_reg)
            2'd0:
            begin
                m_axis_tdata[95:0] = {val_reg[0][2], val_reg[0][1], val_reg[0][0]};
                m_axis_tdata[96] = sat_reg[0];
            end
            2'd1:
            begin
                m_axis_tdata[95:0] = {val_reg[1][2], val_reg[1][1], val_reg[1][0]};
                m_axis_tdata[96] = sat_reg[1];
            end
            2'd2:
            begin
                m_axis_tdata[95:0] = {val_reg[2][2], val_reg[2][1], val_reg[2][0]};
                m_axis_tdata[96] = sat_reg[2];
            end
            default:
            begin
                m_axis_tdata[95:0] = {tr_reg[2], tr_reg[1], tr_reg[0]};
                m_axis_tdata[96] = 1'b0;
            end
        endcase
    end

    assign m_axis_tvalid = v_o_reg;
    assign m_axis_tuser = {col_reg, func_reg};
    assign m_axis_tlast = last_col;

endmodule

`default_nettype wire

FILE: rtl/emnm_checker.sv
`default_nettype none

module emnm_checker
    import emnm_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata,
    input wire logic [2:0]   m_axis_tuser,
    input wire logic         m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tuser[0] == FUNC_MODEL && m_axis_tuser[2:1] == COL_TRANS) ||
            (m_axis_tuser[0] == FUNC_NORMAL && m_axis_tuser[2:1] == COL_LAST_NORMAL))
        else $error("last column flag on wrong column");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser[2:1] == $past(m_axis_tuser[2:1]) + 2'd1)
        else $error("columns of one matrix not consecutive");

    a_trans: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] == COL_TRANS |->
            !m_axis_tdata[96] && m_axis_tuser[0] == FUNC_MODEL)
        else $error("translation column flagged or in normal matrix");

endmodule

bind euler_model_normal_matrix emnm_checker u_emnm_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
    import emnm_pkg::*;

    localparam int ITERS = 16;
    localparam int N_RANDOM = 390;

    typedef struct {
        logic        which;
        logic [1:0]  col;
        logic [31:0] row0;
        logic [31:0] row1;
        logic [31:0] row2;
        logic        sat;
        logic        last;
    } column_t;

    typedef struct {
        logic              func;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [15:0] sc[3];
        logic signed [31:0] tr[3];
    } object_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int error_count = 0;

    euler_model_normal_matrix #(.CORDIC_ITERATIONS(ITERS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round30(input longint a, input longint b);
        return floor_shift(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint clamp32(input longint v, inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void cordic_sincos(input logic signed [15:0] ang,
                                          output longint sn, output longint cs);
        longint z, x, y, nx;
        longint atan_tab[24];
        logic flip;
        atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                     16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                     262144, 131072, 65536, 32768, 16384, 8192,
                     4096, 2048, 1024, 512, 256, 128};
        z = longint'(ang) * 131072;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < ITERS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= atan_tab[i];
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += atan_tab[i];
            end
            x = nx;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    class matrix_scoreboard;
        column_t pending[$];

        function void note_object(input object_t ob);
            longint s1, c1, s2, c2, s3, c3, sc, recip, mag;
            longint rot[3][3];
            longint v[3];
            column_t c;
            logic sat;
            cordic_sincos(ob.rot_y, s1, c1);
            cordic_sincos(ob.rot_x, s2, c2);
            cordic_sincos(ob.rot_z, s3, c3);
            rot[0][0] = round30(c1, c3) + round30(round30(s1, s2), s3);
            rot[0][1] = round30(c2, s3);
            rot[0][2] = round30(round30(c1, s2), s3) - round30(c3, s1);
            rot[1][0] = round30(round30(c3, s1), s2) - round30(c1, s3);
            rot[1][1] = round30(c2, c3);
            rot[1][2] = round30(round30(c1, c3), s2) + round30(s1, s3);
            rot[2][0] = round30(c2, s1);
            rot[2][1] = -s2;
            rot[2][2] = round30(c1, c2);
            for (int k = 0; k < 3; k++) begin
                sc = ob.sc[k];
                sat = 1'b0;
                if (ob.func == FUNC_MODEL) begin
                    for (int r = 0; r < 3; r++)
                        v[r] = clamp32(floor_shift(sc * rot[k][r] + (64'sd1 <<< 21), 22),
                                       sat);
                end else begin
                    if (sc == 0) begin
                        recip = 64'sd2147483647;
                        sat = 1'b1;
                    end else begin
                        mag = sc < 0 ? -sc : sc;
                        recip = ((64'sd1 <<< 24) + mag / 2) / mag;
                        if (sc < 0)
                            recip = -recip;
                    end
                    for (int r = 0; r < 3; r++)
                        v[r] = clamp32(floor_shift(recip * rot[k][r] + (64'sd1 <<< 29), 30),
                                       sat);
                end
                c.which = ob.func;
                c.col = 2'(k);
                c.row0 = v[0][31:0];
                c.row1 = v[1][31:0];
                c.row2 = v[2][31:0];
                c.sat = sat;
                c.last = (ob.func == FUNC_NORMAL) && (k == 2);
                pending.push_back(c);
            end
            if (ob.func == FUNC_MODEL) begin
                c.which = FUNC_MODEL;
                c.col = COL_TRANS;
                c.row0 = ob.tr[0];
                c.row1 = ob.tr[1];
                c.row2 = ob.tr[2];
                c.sat = 1'b0;
                c.last = 1'b1;
                pending.push_back(c);
            end
        endfunction

        task check_column(input column_t got);
            column_t want;
            if (pending.size() == 0) begin
                report("column with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.which !== want.which)
                report($sformatf("which_matrix %0d, expected %0d", got.which, want.which));
            if (got.col !== want.col)
                report($sformatf("column_index %0d, expected %0d", got.col, want.col));
            if (got.row0 !== want.row0)
                report($sformatf("col %0d row0 %h, expected %h", want.col, got.row0, want.row0));
            if (got.row1 !== want.row1)
                report($sformatf("col %0d row1 %h, expected %h", want.col, got.row1, want.row1));
            if (got.row2 !== want.row2)
                report($sformatf("col %0d row2 %h, expected %h", want.col, got.row2, want.row2));
            if (got.sat !== want.sat)
                report($sformatf("col %0d saturated %0d, expected %0d", want.col, got.sat,
                                 want.sat));
            if (got.last !== want.last)
                report($sformatf("col %0d tlast %0d, expected %0d", want.col, got.last,
                                 want.last));
        endtask
    endclass

    matrix_scoreboard board = new();

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [15:0] pick_scale();
        case ($urandom_range(0, 9))
            0: return 16'sh0000;
            1: return 16'sh7FFF;
            2: return 16'sh8000;
            3: return 16'sh0001;
            4: return 16'shFFFF;
            5: return 16'($urandom_range(0, 1023)) - 16'sd512;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_object(input object_t ob);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ob.func;
        s_axis_tdata <= {ob.tr[2], ob.tr[1], ob.tr[0], ob.sc[2], ob.sc[1], ob.sc[0],
                         ob.rot_z, ob.rot_y, ob.rot_x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_object(ob);
    endtask

    function automatic object_t make_object(input logic f, input logic signed [15:0] rx,
                                            input logic signed [15:0] ry,
                                            input logic signed [15:0] rz,
                                            input logic signed [15:0] sv);
        object_t ob;
        ob.func = f;
        ob.rot_x = rx;
        ob.rot_y = ry;
        ob.rot_z = rz;
        for (int k = 0; k < 3; k++) begin
            ob.sc[k] = sv;
            ob.tr[k] = 32'($urandom());
        end
        return ob;
    endfunction

    always @(posedge clk)
    begin
        column_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.row0 = m_axis_tdata[31:0];
            got.row1 = m_axis_tdata[63:32];
            got.row2 = m_axis_tdata[95:64];
            got.sat = m_axis_tdata[96];
            got.which = m_axis_tuser[0];
            got.col = m_axis_tuser[2:1];
            got.last = m_axis_tlast;
            board.check_column(got);
        end
    end

    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge clk);
            stall = gap_length();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall)
                    @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        object_t ob;
        int waited;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_object(make_object(FUNC_MODEL, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100));
        send_object(make_object(FUNC_NORMAL, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100));
        send_object(make_object(FUNC_MODEL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_object(make_object(FUNC_MODEL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        send_object(make_object(FUNC_NORMAL, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000));
        send_object(make_object(FUNC_NORMAL, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001));
        send_object(make_object(FUNC_NORMAL, 16'sh3244, 16'shCDBC, 16'sh3245, 16'shFFFF));
        send_object(make_object(FUNC_NORMAL, 16'sh3243, 16'sh3243, 16'sh3243, 16'sh8000));
        send_object(make_object(FUNC_NORMAL, 16'shCDBB, 16'sh6488, 16'sh1000, 16'sh7FFF));
        send_object(make_object(FUNC_MODEL, 16'sh1000, 16'shF000, 16'sh6488, 16'shFF00));
        ob = make_object(FUNC_MODEL, 16'sh0800, 16'sh0400, 16'sh0200, 16'sh0100);
        ob.tr[0] = 32'sh7FFFFFFF;
        ob.tr[1] = 32'sh80000000;
        ob.tr[2] = 32'hFFFFFFFF;
        send_object(ob);
        ob = make_object(FUNC_NORMAL, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        ob.sc[1] = 16'sh0100;
        ob.sc[2] = 16'shFF00;
        send_object(ob);

        for (int n = 0; n < N_RANDOM; n++) begin
            ob.func = 1'($urandom_range(0, 1));
            ob.rot_x = pick16();
            ob.rot_y = pick16();
            ob.rot_z = pick16();
            for (int k = 0; k < 3; k++) begin
                ob.sc[k] = pick_scale();
                ob.tr[k] = 32'($urandom());
            end
            send_object(ob);
            if (n == N_RANDOM / 2) begin
                s_axis_tvalid <= 1'b0;
                while (board.pending.size() != 0)
                    @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (60)
            @(posedge clk);
        if (error_count == 0 && board.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
